FILE: sv/ikp_pkg.sv
// shared types, constants and the arctangent table of the two-link arm solver
package ikp_pkg;

    // default number of cordic steps
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_TABLE_LEN        = 24;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int LINK_W     = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LINK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LINK = 8'd1;
    localparam logic [LINK_W-1:0] UPPER_LINK_RESET = 15'd1280;
    localparam logic [LINK_W-1:0] LOWER_LINK_RESET = 15'd1792;

    // datapath widths
    localparam int SQ1_N = 24;   // root bits of r
    localparam int SQ2_N = 21;   // root bits of the sine
    localparam int DIV_W = 41;   // divider operand width
    localparam int QW    = 21;   // cosine magnitude bits
    localparam int XW    = 36;   // cordic x/y width
    localparam int ZW    = 26;   // cordic angle width
    localparam int AW    = 28;   // angle difference width

    // angles in 2^-16 degree and output limits in 1/64 degree
    localparam int DEG90  = 90 * 65536;
    localparam int DEG180 = 180 * 65536;
    localparam int SH_MIN = -23040;
    localparam int SH_MAX = 11520;
    localparam int EL_MAX = 11520;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } ikp_in_t;

    typedef struct packed {
        logic signed [15:0] shoulder_angle;
        logic        [13:0] elbow_angle;
        logic               unreachable;
    } ikp_out_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic int atan_entry(input int i);
        int v;
        case (i)
            0:       v = 2949120;
            1:       v = 1740967;
            2:       v = 919879;
            3:       v = 466945;
            4:       v = 234379;
            5:       v = 117304;
            6:       v = 58666;
            7:       v = 29335;
            8:       v = 14668;
            9:       v = 7334;
            10:      v = 3667;
            11:      v = 1833;
            12:      v = 917;
            13:      v = 458;
            14:      v = 229;
            15:      v = 115;
            16:      v = 57;
            17:      v = 29;
            18:      v = 14;
            19:      v = 7;
            20:      v = 4;
            21:      v = 2;
            22:      v = 1;
            default: v = 0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ikp_sqrt_cell.sv
// one digit step of a pipelined integer square root, several lanes in lockstep
module ikp_sqrt_cell #(
    parameter int N     = 24,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [2*N-1:0]       in_v    [LANES],
    input  logic [N+1:0]         in_rem  [LANES],
    input  logic [N-1:0]         in_root [LANES],
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic [2*N-1:0]       out_v    [LANES],
    output logic [N+1:0]         out_rem  [LANES],
    output logic [N-1:0]         out_root [LANES],
    output logic [SW-1:0]        out_side
);

    logic           valid_reg;
    logic [2*N-1:0] v_reg    [LANES];
    logic [N+1:0]   rem_reg  [LANES];
    logic [N-1:0]   root_reg [LANES];
    logic [SW-1:0]  side_reg;
    logic [2*N-1:0] v_next    [LANES];
    logic [N+1:0]   rem_next  [LANES];
    logic [N-1:0]   root_next [LANES];
    logic [N+3:0]   acc       [LANES];
    logic [N+3:0]   trial     [LANES];

    // bring down two bits and try the next root digit
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            acc[l]   = {in_rem[l], in_v[l][2*N-1 -: 2]};
            trial[l] = {2'b00, in_root[l], 2'b01};
            v_next[l] = {in_v[l][2*N-3:0], 2'b00};
            if (acc[l] >= trial[l]) begin
                rem_next[l]  = (N+2)'(acc[l] - trial[l]);
                root_next[l] = {in_root[l][N-2:0], 1'b1};
            end else begin
                rem_next[l]  = (N+2)'(acc[l]);
                root_next[l] = {in_root[l][N-2:0], 1'b0};
            end
        end
    end

    // valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg    <= v_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/ikp_div_cell.sv
// one quotient bit of a pipelined restoring divider, several lanes in lockstep
module ikp_div_cell #(
    parameter int DW    = 41,
    parameter int QBITS = 21,
    parameter int LANES = 2,
    parameter int SW    = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [DW:0]       in_rem [LANES],
    input  logic [DW-1:0]     in_den [LANES],
    input  logic [QBITS-1:0]  in_q   [LANES],
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [DW:0]       out_rem [LANES],
    output logic [DW-1:0]     out_den [LANES],
    output logic [QBITS-1:0]  out_q   [LANES],
    output logic [SW-1:0]     out_side
);

    logic             valid_reg;
    logic [DW:0]      rem_reg [LANES];
    logic [DW-1:0]    den_reg [LANES];
    logic [QBITS-1:0] q_reg   [LANES];
    logic [SW-1:0]    side_reg;
    logic [DW:0]      rem_next [LANES];
    logic [QBITS-1:0] q_next   [LANES];
    logic [DW:0]      diff     [LANES];
    logic             ge       [LANES];

    // compare, subtract, shift the remainder up
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            ge[l]   = in_rem[l] >= {1'b0, in_den[l]};
            diff[l] = in_rem[l] - {1'b0, in_den[l]};
            if (ge[l]) begin
                rem_next[l] = {diff[l][DW-1:0], 1'b0};
            end else begin
                rem_next[l] = {in_rem[l][DW-1:0], 1'b0};
            end
            q_next[l] = {in_q[l][QBITS-2:0], ge[l]};
        end
    end

    // valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/ikp_cordic_cell.sv
// one vectoring step of a pipelined cordic, several lanes in lockstep
module ikp_cordic_cell #(
    parameter int IDX   = 0,
    parameter int XW    = 36,
    parameter int ZW    = 26,
    parameter int LANES = 3,
    parameter int SW    = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [XW-1:0] in_x [LANES],
    input  logic signed [XW-1:0] in_y [LANES],
    input  logic signed [ZW-1:0] in_z [LANES],
    input  logic [SW-1:0]        in_side,
    output logic                 out_valid,
    output logic signed [XW-1:0] out_x [LANES],
    output logic signed [XW-1:0] out_y [LANES],
    output logic signed [ZW-1:0] out_z [LANES],
    output logic [SW-1:0]        out_side
);

    localparam int ATAN = ikp_pkg::atan_entry(IDX);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg [LANES];
    logic signed [XW-1:0] y_reg [LANES];
    logic signed [ZW-1:0] z_reg [LANES];
    logic [SW-1:0]        side_reg;
    logic signed [XW-1:0] x_next [LANES];
    logic signed [XW-1:0] y_next [LANES];
    logic signed [ZW-1:0] z_next [LANES];
    logic signed [XW-1:0] xs     [LANES];
    logic signed [XW-1:0] ys     [LANES];

    // rotate toward the x axis, floor shifts
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            xs[l] = in_x[l] >>> IDX;
            ys[l] = in_y[l] >>> IDX;
            if (!in_y[l][XW-1]) begin
                x_next[l] = in_x[l] + ys[l];
                y_next[l] = in_y[l] - xs[l];
                z_next[l] = in_z[l] + ZW'(ATAN);
            end else begin
                x_next[l] = in_x[l] - ys[l];
                y_next[l] = in_y[l] + xs[l];
                z_next[l] = in_z[l] - ZW'(ATAN);
            end
        end
    end

    // valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

FILE: sv/two_link_planar_inverse_kinematics.sv
// throughput: one item per cycle while the output buffer is not full, as a full
// buffer stalls the whole row; the row is set by 24 root cells for r, 21 divider
// cells and 21 root cells for the sines (one result bit each), then the cordic cells
// a two-entry output buffer lets the row keep moving while one result waits
// reset (synchronous, active low) clears all valid bits and the buffer, and sets
// the link lengths to 5.0 and 7.0
module two_link_planar_inverse_kinematics #(
    parameter int CORDIC_ITERATIONS = ikp_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ikp_pkg::ikp_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ikp_pkg::ikp_out_t                m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ikp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ikp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int N1 = ikp_pkg::SQ1_N;
    localparam int N2 = ikp_pkg::SQ2_N;
    localparam int DW = ikp_pkg::DIV_W;
    localparam int QW = ikp_pkg::QW;
    localparam int XW = ikp_pkg::XW;
    localparam int ZW = ikp_pkg::ZW;
    localparam int AW = ikp_pkg::AW;
    localparam int LW = ikp_pkg::LINK_W;
    localparam int NI = CORDIC_ITERATIONS;

    // ---------------- configuration ----------------
    logic [LW-1:0]    upper_reg;
    logic [LW-1:0]    lower_reg;
    logic [2*LW-1:0]  a1sq_reg;
    logic [2*LW-1:0]  a2sq_reg;
    logic [2*LW:0]    den3_reg;
    logic [2*LW-1:0]  a1a2_next;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= ikp_pkg::UPPER_LINK_RESET;
            lower_reg <= ikp_pkg::LOWER_LINK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ikp_pkg::CFG_UPPER_LINK: upper_reg <= cfg_data[LW-1:0];
                ikp_pkg::CFG_LOWER_LINK: lower_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // link products, refreshed every cycle
    assign a1a2_next = upper_reg * lower_reg;
    always_ff @(posedge aclk) begin
        a1sq_reg <= upper_reg * upper_reg;
        a2sq_reg <= lower_reg * lower_reg;
        den3_reg <= {a1a2_next, 1'b0};
    end

    // ---------------- flow control ----------------
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    ikp_pkg::ikp_out_t buf0_reg;
    ikp_pkg::ikp_out_t buf1_reg;
    ikp_pkg::ikp_out_t res_next;
    logic              ce;
    logic              push;
    logic              pop;
    logic              h_valid_reg;

    assign ce      = (cnt_reg != 2'd2);
    assign s_ready = ce;
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = buf0_reg;
    assign pop     = m_valid && m_ready;
    assign push    = ce && h_valid_reg;

    // ---------------- stage a: squares ----------------
    logic                a_valid_reg;
    logic signed [15:0]  a_x_reg;
    logic signed [15:0]  a_y_reg;
    logic signed [31:0]  a_xx_reg;
    logic signed [31:0]  a_yy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_x_reg  <= s_data.target_x;
            a_y_reg  <= s_data.target_y;
            a_xx_reg <= s_data.target_x * s_data.target_x;
            a_yy_reg <= s_data.target_y * s_data.target_y;
        end
    end

    // ---------------- stage b: r squared ----------------
    logic               b_valid_reg;
    logic signed [15:0] b_x_reg;
    logic signed [15:0] b_y_reg;
    logic [31:0]        b_r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_x_reg  <= a_x_reg;
            b_y_reg  <= a_y_reg;
            b_r2_reg <= $unsigned(a_xx_reg) + $unsigned(a_yy_reg);
        end
    end

    // ---------------- root row for r ----------------
    logic [2*N1-1:0] q1_v    [N1+1][1];
    logic [N1+1:0]   q1_rem  [N1+1][1];
    logic [N1-1:0]   q1_root [N1+1][1];
    logic [63:0]     q1_side [N1+1];
    logic            q1_valid[N1+1];

    assign q1_v[0][0]    = {b_r2_reg, 16'b0};
    assign q1_rem[0][0]  = '0;
    assign q1_root[0][0] = '0;
    assign q1_side[0]    = {b_x_reg, b_y_reg, b_r2_reg};
    assign q1_valid[0]   = b_valid_reg;

    for (genvar k = 0; k < N1; k++) begin : g_sq1
        ikp_sqrt_cell #(.N(N1), .LANES(1), .SW(64)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(q1_valid[k]), .in_v(q1_v[k]), .in_rem(q1_rem[k]),
            .in_root(q1_root[k]), .in_side(q1_side[k]),
            .out_valid(q1_valid[k+1]), .out_v(q1_v[k+1]), .out_rem(q1_rem[k+1]),
            .out_root(q1_root[k+1]), .out_side(q1_side[k+1])
        );
    end

    // ---------------- stage c: cosine numerators and denominator ----------------
    logic               c_valid_reg;
    logic signed [15:0] c_x_reg;
    logic signed [15:0] c_y_reg;
    logic [39:0]        c_den1_reg;
    logic signed [41:0] c_num1_reg;
    logic signed [33:0] c_num3_reg;
    logic               c_rzero_reg;
    logic [N1-1:0]      c_r;
    logic [31:0]        c_r2;
    logic [38:0]        c_a1r;
    logic signed [33:0] c_s34;
    logic signed [33:0] c_num3_next;

    assign c_r   = q1_root[N1][0];
    assign c_r2  = q1_side[N1][31:0];
    assign c_a1r = upper_reg * c_r;
    assign c_s34 = $signed({4'b0, a1sq_reg}) + $signed({2'b0, c_r2})
                 - $signed({4'b0, a2sq_reg});
    assign c_num3_next = $signed({4'b0, a1sq_reg}) + $signed({4'b0, a2sq_reg})
                       - $signed({2'b0, c_r2});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= q1_valid[N1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_x_reg     <= q1_side[N1][63:48];
            c_y_reg     <= q1_side[N1][47:32];
            c_den1_reg  <= {c_a1r, 1'b0};
            c_num1_reg  <= {c_s34, 8'b0};
            c_num3_reg  <= c_num3_next;
            c_rzero_reg <= (c_r == '0);
        end
    end

    // ---------------- stage d: magnitudes and reach test ----------------
    logic               d_valid_reg;
    logic [34:0]        d_side_reg;
    logic [DW-1:0]      d_mag1_reg;
    logic [DW-1:0]      d_den1_reg;
    logic [DW-1:0]      d_mag3_reg;
    logic [DW-1:0]      d_den3_reg;
    logic [41:0]        d_abs1;
    logic [33:0]        d_abs3;
    logic               d_unreach;

    assign d_abs1 = c_num1_reg[41] ? $unsigned(-c_num1_reg) : $unsigned(c_num1_reg);
    assign d_abs3 = c_num3_reg[33] ? $unsigned(-c_num3_reg) : $unsigned(c_num3_reg);
    assign d_unreach = c_rzero_reg || (c_den1_reg == '0) || (den3_reg == '0)
                    || (d_abs1[DW-1:0] > DW'(c_den1_reg))
                    || (d_abs3[32:0] > 33'(den3_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_side_reg <= {c_x_reg, c_y_reg, d_unreach, c_num1_reg[41], c_num3_reg[33]};
            d_mag1_reg <= d_abs1[DW-1:0];
            d_den1_reg <= DW'(c_den1_reg);
            d_mag3_reg <= DW'(d_abs3[32:0]);
            d_den3_reg <= DW'(den3_reg);
        end
    end

    // ---------------- divider row for both cosines ----------------
    logic [DW:0]   dv_rem [QW+1][2];
    logic [DW-1:0] dv_den [QW+1][2];
    logic [QW-1:0] dv_q   [QW+1][2];
    logic [34:0]   dv_side[QW+1];
    logic          dv_valid[QW+1];

    assign dv_rem[0][0] = {1'b0, d_mag1_reg};
    assign dv_rem[0][1] = {1'b0, d_mag3_reg};
    assign dv_den[0][0] = d_den1_reg;
    assign dv_den[0][1] = d_den3_reg;
    assign dv_q[0][0]   = '0;
    assign dv_q[0][1]   = '0;
    assign dv_side[0]   = d_side_reg;
    assign dv_valid[0]  = d_valid_reg;

    for (genvar k = 0; k < QW; k++) begin : g_div
        ikp_div_cell #(.DW(DW), .QBITS(QW), .LANES(2), .SW(35)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(dv_valid[k]), .in_rem(dv_rem[k]), .in_den(dv_den[k]),
            .in_q(dv_q[k]), .in_side(dv_side[k]),
            .out_valid(dv_valid[k+1]), .out_rem(dv_rem[k+1]), .out_den(dv_den[k+1]),
            .out_q(dv_q[k+1]), .out_side(dv_side[k+1])
        );
    end

    // ---------------- stage e: signed cosines and their squares ----------------
    logic               e_valid_reg;
    logic [32:0]        e_side_reg;
    logic signed [QW:0] e_c1_reg;
    logic signed [QW:0] e_c3_reg;
    logic [2*QW-1:0]    e_c1sq_reg;
    logic [2*QW-1:0]    e_c3sq_reg;
    logic [QW-1:0]      e_q1;
    logic [QW-1:0]      e_q3;

    assign e_q1 = dv_q[QW][0];
    assign e_q3 = dv_q[QW][1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (ce) begin
            e_valid_reg <= dv_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_side_reg <= dv_side[QW][34:2];
            e_c1_reg   <= dv_side[QW][1] ? -$signed({1'b0, e_q1}) : $signed({1'b0, e_q1});
            e_c3_reg   <= dv_side[QW][0] ? -$signed({1'b0, e_q3}) : $signed({1'b0, e_q3});
            e_c1sq_reg <= e_q1 * e_q1;
            e_c3sq_reg <= e_q3 * e_q3;
        end
    end

    // ---------------- stage f: one minus cosine squared ----------------
    localparam logic [2*QW-1:0] ONE_SQ = 42'h100_0000_0000;

    logic               f_valid_reg;
    logic [76:0]        f_side_reg;
    logic [2*N2-1:0]    f_v1_reg;
    logic [2*N2-1:0]    f_v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_side_reg <= {e_c1_reg, e_c3_reg, e_side_reg};
            f_v1_reg   <= (e_c1sq_reg >= ONE_SQ) ? '0 : (2*N2)'(ONE_SQ - e_c1sq_reg);
            f_v3_reg   <= (e_c3sq_reg >= ONE_SQ) ? '0 : (2*N2)'(ONE_SQ - e_c3sq_reg);
        end
    end

    // ---------------- root row for the sines ----------------
    logic [2*N2-1:0] q2_v    [N2+1][2];
    logic [N2+1:0]   q2_rem  [N2+1][2];
    logic [N2-1:0]   q2_root [N2+1][2];
    logic [76:0]     q2_side [N2+1];
    logic            q2_valid[N2+1];

    assign q2_v[0][0]    = f_v1_reg;
    assign q2_v[0][1]    = f_v3_reg;
    assign q2_rem[0][0]  = '0;
    assign q2_rem[0][1]  = '0;
    assign q2_root[0][0] = '0;
    assign q2_root[0][1] = '0;
    assign q2_side[0]    = f_side_reg;
    assign q2_valid[0]   = f_valid_reg;

    for (genvar k = 0; k < N2; k++) begin : g_sq2
        ikp_sqrt_cell #(.N(N2), .LANES(2), .SW(77)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(q2_valid[k]), .in_v(q2_v[k]), .in_rem(q2_rem[k]),
            .in_root(q2_root[k]), .in_side(q2_side[k]),
            .out_valid(q2_valid[k+1]), .out_v(q2_v[k+1]), .out_rem(q2_rem[k+1]),
            .out_root(q2_root[k+1]), .out_side(q2_side[k+1])
        );
    end

    // ---------------- quadrant pre-rotation into the cordic row ----------------
    logic signed [XW-1:0] cd_x [NI+1][3];
    logic signed [XW-1:0] cd_y [NI+1][3];
    logic signed [ZW-1:0] cd_z [NI+1][3];
    logic                 cd_side [NI+1];
    logic                 cd_valid[NI+1];
    logic signed [XW-1:0] g_x [3];
    logic signed [XW-1:0] g_y [3];
    logic signed [QW:0]   g_c1;
    logic signed [QW:0]   g_c3;
    logic signed [15:0]   g_tx;
    logic signed [15:0]   g_ty;

    assign g_c1 = q2_side[N2][76:55];
    assign g_c3 = q2_side[N2][54:33];
    assign g_tx = q2_side[N2][32:17];
    assign g_ty = q2_side[N2][16:1];

    always_comb begin
        g_x[0] = $signed({{(XW-32){g_tx[15]}}, g_tx, 16'b0});
        g_y[0] = $signed({{(XW-32){g_ty[15]}}, g_ty, 16'b0});
        g_x[1] = $signed({{(XW-QW-9){g_c1[QW]}}, g_c1, 8'b0});
        g_y[1] = $signed({{(XW-N2-8){1'b0}}, q2_root[N2][0], 8'b0});
        g_x[2] = $signed({{(XW-QW-9){g_c3[QW]}}, g_c3, 8'b0});
        g_y[2] = $signed({{(XW-N2-8){1'b0}}, q2_root[N2][1], 8'b0});
        for (int l = 0; l < 3; l++) begin
            if (!g_x[l][XW-1]) begin
                cd_x[0][l] = g_x[l];
                cd_y[0][l] = g_y[l];
                cd_z[0][l] = '0;
            end else if (!g_y[l][XW-1]) begin
                cd_x[0][l] = g_y[l];
                cd_y[0][l] = -g_x[l];
                cd_z[0][l] = ZW'(ikp_pkg::DEG90);
            end else begin
                cd_x[0][l] = -g_y[l];
                cd_y[0][l] = g_x[l];
                cd_z[0][l] = -ZW'(ikp_pkg::DEG90);
            end
        end
    end

    assign cd_side[0]  = q2_side[N2][0];
    assign cd_valid[0] = q2_valid[N2];

    // ---------------- cordic row: target angle and both arccosines ----------------
    for (genvar k = 0; k < NI; k++) begin : g_cordic
        ikp_cordic_cell #(.IDX(k), .XW(XW), .ZW(ZW), .LANES(3), .SW(1)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .ce(ce),
            .in_valid(cd_valid[k]), .in_x(cd_x[k]), .in_y(cd_y[k]), .in_z(cd_z[k]),
            .in_side(cd_side[k]),
            .out_valid(cd_valid[k+1]), .out_x(cd_x[k+1]), .out_y(cd_y[k+1]),
            .out_z(cd_z[k+1]), .out_side(cd_side[k+1])
        );
    end

    // ---------------- stage h: joint angles in 2^-16 degree ----------------
    logic               h_flag_reg;
    logic signed [AW-1:0] h_sh_reg;
    logic signed [AW-1:0] h_el_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (ce) begin
            h_valid_reg <= cd_valid[NI];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_flag_reg <= cd_side[NI];
            h_sh_reg   <= AW'(cd_z[NI][0]) - AW'(cd_z[NI][1]);
            h_el_reg   <= AW'(ikp_pkg::DEG180) - AW'(cd_z[NI][2]);
        end
    end

    // ---------------- rounding to 1/64 degree and clamping ----------------
    logic signed [AW-1:0] sh_t;
    logic signed [AW-1:0] el_t;
    logic signed [AW-1:0] sh_c;
    logic signed [AW-1:0] el_c;

    always_comb begin
        sh_t = (h_sh_reg + AW'(512)) >>> 10;
        el_t = (h_el_reg + AW'(512)) >>> 10;
        if (sh_t < $signed(AW'(ikp_pkg::SH_MIN))) begin
            sh_c = $signed(AW'(ikp_pkg::SH_MIN));
        end else if (sh_t > $signed(AW'(ikp_pkg::SH_MAX))) begin
            sh_c = $signed(AW'(ikp_pkg::SH_MAX));
        end else begin
            sh_c = sh_t;
        end
        if (el_t[AW-1]) begin
            el_c = '0;
        end else if (el_t > $signed(AW'(ikp_pkg::EL_MAX))) begin
            el_c = $signed(AW'(ikp_pkg::EL_MAX));
        end else begin
            el_c = el_t;
        end
        if (h_flag_reg) begin
            res_next.shoulder_angle = '0;
            res_next.elbow_angle    = '0;
            res_next.unreachable    = 1'b1;
        end else begin
            res_next.shoulder_angle = sh_c[15:0];
            res_next.elbow_angle    = el_c[13:0];
            res_next.unreachable    = 1'b0;
        end
    end

    // ---------------- output buffer ----------------
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // head takes the new result when the buffer drains to it, else shifts up
    always_ff @(posedge aclk) begin
        if (push && ((cnt_reg - {1'b0, pop}) == 2'd0)) begin
            buf0_reg <= res_next;
        end else if (pop) begin
            buf0_reg <= buf1_reg;
        end
        if (push && ((cnt_reg - {1'b0, pop}) != 2'd0)) begin
            buf1_reg <= res_next;
        end
    end

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (cnt_reg == 2'd2 && m_valid))
        else $error("input stalled without a full output buffer");

    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.unreachable) |->
            (m_data.shoulder_angle == '0 && m_data.elbow_angle == '0))
        else $error("unreachable result carries nonzero angles");

    a_drop_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without being taken");

    a_elbow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.elbow_angle <= 14'(ikp_pkg::EL_MAX)))
        else $error("elbow angle above limit");

endmodule
